// ===== sv/rpd_pkg.sv =====
// Shared types and constants for the range page directory.
`timescale 1ns / 1ps
`default_nettype none
package rpd_pkg;

  localparam logic [6:0] PS_LO    = 7'd25;
  localparam logic [6:0] PS_HI    = 7'd100;
  localparam logic [6:0] PS_HALF  = 7'd50;
  localparam logic [2:0] MP_LO    = 3'd2;
  localparam logic [6:0] FETCH_HI = 7'd100;
  localparam logic [6:0] PS_RST   = 7'd50;
  localparam logic [2:0] MP_RST   = 3'd5;
  localparam logic [6:0] PM_RST   = 7'd10;
  localparam int         ADDR_W   = 4;

  typedef enum logic [1:0] {
    REG_PAGE_SIZE = 2'd0,
    REG_MAX_PAGES = 2'd1,
    REG_PF_MARGIN = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    REQ_INSERT   = 3'd0,
    REQ_REMOVE   = 3'd1,
    REQ_LOAD     = 3'd2,
    REQ_READ     = 3'd3,
    REQ_PREFETCH = 3'd4,
    REQ_CLEAR    = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_MISS   = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SCAN_HOLD,
    SCAN_ADJ,
    SCAN_KEY,
    SCAN_LRU
  } smode_t;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LATCH,
    CMD_SEED,
    CMD_SCAN,
    CMD_BUMP,
    CMD_SHRINK,
    CMD_TOUCH,
    CMD_SHIFT_UP,
    CMD_SHIFT_DN,
    CMD_DROP,
    CMD_SPLIT,
    CMD_CLEAR,
    CMD_CNT_INIT,
    CMD_CNT_STEP,
    CMD_REJECT,
    CMD_BLK_INIT,
    CMD_BLK_APPEND,
    CMD_PROBE,
    CMD_DIV,
    CMD_ALIGN,
    CMD_PF_SET,
    CMD_OUT_LOAD
  } cmd_t;

  typedef struct packed {
    cmd_t   op;
    smode_t mode;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic hit;
    logic used_zero;
    logic used_full;
    logic split_need;
    logic over_cap;
    logic slot_valid;
    logic cnt_end;
    logic add_over;
    logic evict_need;
    logic blk_more;
    logic want;
    logic al_ok;
    req_t req;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== sv/rpd_datapath.sv =====
// Directory storage, scan unit, remainder unit and result registers.
`timescale 1ns / 1ps
`default_nettype none
module rpd_datapath #(
  parameter int PAGE_SLOTS    = 8,
  parameter int POSITION_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rpd_pkg::dp_cmd_t         cmd,
  output rpd_pkg::dp_stat_t        stat,
  input  logic [6:0]               cfg_page_size,
  input  logic [2:0]               cfg_max_pages,
  input  logic [6:0]               cfg_margin,
  input  logic [2:0]               in_req_type,
  input  logic [POSITION_BITS-1:0] in_position,
  input  logic [9:0]               in_item_count,
  output logic [1:0]               out_status,
  output logic [2:0]               out_page_slot,
  output logic [2:0]               out_pages_dropped,
  output logic                     out_prefetch_valid,
  output logic [POSITION_BITS-1:0] out_prefetch_start,
  output logic [6:0]               out_fetch_size,
  output logic [2:0]               out_pages_in_use,
  output logic [9:0]               out_items_cached
);
  import rpd_pkg::*;

  localparam int PW     = POSITION_BITS;
  localparam int KW     = PW + 1;
  localparam int SW     = $clog2(PAGE_SLOTS);
  localparam int UW     = $clog2(PAGE_SLOTS + 1);
  localparam int UWX    = (UW < 3) ? 3 : UW;
  localparam int SWX    = (SW < 3) ? 3 : SW;
  localparam int EW     = ((UW > 4) ? UW : 4) + 1;
  localparam int TW_RAW = $clog2(PAGE_SLOTS * 127 + 1);
  localparam int TW     = (TW_RAW < 10) ? 10 : TW_RAW;
  localparam int CW     = $clog2(KW + 1);
  localparam int MP_LIM = (PAGE_SLOTS - 1 < 7) ? PAGE_SLOTS - 1 : 7;
  localparam logic [KW-1:0] TOP = {1'b0, {PW{1'b1}}};

  logic [PW-1:0] start_r [PAGE_SLOTS];
  logic [6:0]    len_r   [PAGE_SLOTS];
  logic [31:0]   stamp_r [PAGE_SLOTS];

  req_t          req_r;
  logic [PW-1:0] pos_r;
  logic [9:0]    cnt_r;
  logic [UW-1:0] used_r;
  logic [31:0]   clock_r;
  logic [TW-1:0] total_r;
  logic [SW-1:0] slot_r;
  logic          slot_valid_r;
  logic [PW-1:0] m_start_r;
  logic [6:0]    m_len_r;
  logic [2:0]    dropped_r;
  logic          reject_r;
  logic          pvalid_r;
  logic [PW-1:0] pstart_r;
  logic [SW-1:0] cur_r;
  logic          scan_busy_r;
  smode_t        mode_r;
  logic          hit_r;
  logic [SW-1:0] best_r;
  logic [31:0]   best_stamp_r;
  logic [6:0]    best_len_r;
  logic [9:0]    rem_r;
  logic [3:0]    add_r;
  logic [3:0]    bi_r;
  logic [KW-1:0] bst_r;
  logic [9:0]    left_r;
  logic          want_r;
  logic [KW-1:0] key_r;
  logic          div_busy_r;
  logic [CW-1:0] div_cnt_r;
  logic [6:0]    div_rem_r;
  logic [KW-1:0] div_sh_r;
  logic [1:0]    o_status_r;
  logic [2:0]    o_slot_r;
  logic [2:0]    o_dropped_r;
  logic          o_pvalid_r;
  logic [PW-1:0] o_pstart_r;
  logic [6:0]    o_fetch_r;
  logic [2:0]    o_used_r;
  logic [9:0]    o_items_r;

  logic [6:0]    ps;
  logic [2:0]    mp_c;
  logic [2:0]    mp;
  logic [9:0]    cap;
  logic [PW-1:0] e_start;
  logic [6:0]    e_len;
  logic [31:0]   e_stamp;
  logic [KW-1:0] e_lo;
  logic [KW-1:0] e_end;
  logic [KW-1:0] key;
  logic          e_match;
  logic          e_last;
  logic [6:0]    lo;
  logic [KW-1:0] hs;
  logic [PW-1:0] hs_sat;
  logic [KW-1:0] bst_nxt;
  logic [6:0]    blk_len;
  logic [PW-1:0] d_lo;
  logic [KW-1:0] m_end;
  logic [KW-1:0] d_hi;
  logic [7:0]    r2;
  logic [7:0]    r2_nxt;
  logic [UWX-1:0] used_x;
  logic [SWX-1:0] slot_x;
  logic          miss;

  always_comb begin
    if (cfg_page_size < PS_LO) begin
      ps = PS_LO;
    end else if (cfg_page_size > PS_HI) begin
      ps = PS_HI;
    end else begin
      ps = cfg_page_size;
    end
    mp_c = (cfg_max_pages < MP_LO) ? MP_LO : cfg_max_pages;
    mp   = (mp_c > 3'(MP_LIM)) ? 3'(MP_LIM) : mp_c;
    cap  = 10'(ps) * 10'(mp);
  end

  assign e_start = start_r[cur_r];
  assign e_len   = len_r[cur_r];
  assign e_stamp = stamp_r[cur_r];
  assign e_lo    = {1'b0, e_start};
  assign e_end   = e_lo + KW'(e_len);
  assign key     = (mode_r == SCAN_KEY) ? key_r : {1'b0, pos_r};
  assign e_match = (mode_r == SCAN_ADJ) ? (key >= e_lo && key <= e_end)
                                        : (key >= e_lo && key < e_end);
  assign e_last  = (UW'(cur_r) + UW'(1)) == used_r;

  assign lo      = m_len_r >> 1;
  assign hs      = {1'b0, m_start_r} + KW'(lo);
  assign hs_sat  = (hs > TOP) ? TOP[PW-1:0] : hs[PW-1:0];
  assign bst_nxt = ((bst_r + KW'(ps)) > TOP) ? TOP : bst_r + KW'(ps);
  assign blk_len = (left_r > 10'(ps)) ? ps : left_r[6:0];
  assign d_lo    = pos_r - m_start_r;
  assign m_end   = {1'b0, m_start_r} + KW'(m_len_r);
  assign d_hi    = m_end - {1'b0, pos_r};
  assign r2      = {div_rem_r, div_sh_r[KW-1]};
  assign r2_nxt  = (r2 >= {1'b0, ps}) ? r2 - {1'b0, ps} : r2;
  assign used_x  = UWX'(used_r);
  assign slot_x  = SWX'(slot_r);
  assign miss    = !slot_valid_r && dropped_r == 3'd0 &&
                   (req_r == REQ_INSERT || req_r == REQ_REMOVE ||
                    req_r == REQ_READ || req_r == REQ_PREFETCH);

  always_comb begin
    stat.busy       = scan_busy_r | div_busy_r;
    stat.hit        = hit_r;
    stat.used_zero  = used_r == '0;
    stat.used_full  = used_r >= UW'(PAGE_SLOTS);
    stat.split_need = m_len_r > ps;
    stat.over_cap   = total_r > TW'(cap);
    stat.slot_valid = slot_valid_r;
    stat.cnt_end    = rem_r == 10'd0 || add_r > {1'b0, mp};
    stat.add_over   = add_r > {1'b0, mp};
    stat.evict_need = (EW'(used_r) + EW'(add_r)) > EW'(mp) && used_r != '0;
    stat.blk_more   = bi_r < add_r;
    stat.want       = want_r;
    stat.al_ok      = key_r <= TOP;
    stat.req        = req_r;
  end

  for (genvar g = 0; g < PAGE_SLOTS; g++) begin : g_entry
    localparam int NX = (g < PAGE_SLOTS - 1) ? g + 1 : g;
    logic is_slot;
    logic is_used;
    logic at_drop;
    assign is_slot = slot_r == SW'(g);
    assign is_used = used_r == UW'(g);
    assign at_drop = best_r <= SW'(g) && g < PAGE_SLOTS - 1;

    always_ff @(posedge clk) begin
      case (cmd.op)
        CMD_SEED: begin
          if (is_used) begin
            start_r[g] <= pos_r;
            len_r[g]   <= 7'd0;
            stamp_r[g] <= clock_r + 32'd1;
          end
        end
        CMD_BUMP: begin
          if (is_slot) begin
            len_r[g]   <= m_len_r + 7'd1;
            stamp_r[g] <= clock_r + 32'd1;
          end
        end
        CMD_SHRINK: begin
          if (is_slot) begin
            len_r[g]   <= m_len_r - 7'd1;
            stamp_r[g] <= clock_r + 32'd1;
          end
        end
        CMD_TOUCH: begin
          if (is_slot) begin
            stamp_r[g] <= clock_r + 32'd1;
          end
        end
        CMD_SHIFT_UP: begin
          if (start_r[g] > pos_r && start_r[g] != TOP[PW-1:0]) begin
            start_r[g] <= start_r[g] + PW'(1);
          end
        end
        CMD_SHIFT_DN: begin
          if (start_r[g] > pos_r) begin
            start_r[g] <= start_r[g] - PW'(1);
          end
        end
        CMD_DROP: begin
          if (at_drop) begin
            start_r[g] <= start_r[NX];
            len_r[g]   <= len_r[NX];
            stamp_r[g] <= stamp_r[NX];
          end
        end
        CMD_SPLIT: begin
          if (is_slot) begin
            len_r[g] <= lo;
          end else if (is_used) begin
            start_r[g] <= hs_sat;
            len_r[g]   <= m_len_r - lo;
            stamp_r[g] <= clock_r;
          end
        end
        CMD_BLK_APPEND: begin
          if (is_used) begin
            start_r[g] <= bst_r[PW-1:0];
            len_r[g]   <= blk_len;
            stamp_r[g] <= clock_r + 32'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r        <= REQ_CLEAR;
      pos_r        <= '0;
      cnt_r        <= '0;
      used_r       <= '0;
      clock_r      <= 32'd1;
      total_r      <= '0;
      slot_r       <= '0;
      slot_valid_r <= 1'b0;
      m_start_r    <= '0;
      m_len_r      <= '0;
      dropped_r    <= '0;
      reject_r     <= 1'b0;
      pvalid_r     <= 1'b0;
      pstart_r     <= '0;
      cur_r        <= '0;
      scan_busy_r  <= 1'b0;
      mode_r       <= SCAN_HOLD;
      hit_r        <= 1'b0;
      best_r       <= '0;
      best_stamp_r <= '0;
      best_len_r   <= '0;
      rem_r        <= '0;
      add_r        <= '0;
      bi_r         <= '0;
      bst_r        <= '0;
      left_r       <= '0;
      want_r       <= 1'b0;
      key_r        <= '0;
      div_busy_r   <= 1'b0;
      div_cnt_r    <= '0;
      div_rem_r    <= '0;
      div_sh_r     <= '0;
      o_status_r   <= '0;
      o_slot_r     <= '0;
      o_dropped_r  <= '0;
      o_pvalid_r   <= 1'b0;
      o_pstart_r   <= '0;
      o_fetch_r    <= '0;
      o_used_r     <= '0;
      o_items_r    <= '0;
    end else begin
      if (scan_busy_r) begin
        cur_r <= cur_r + SW'(1);
        if (mode_r == SCAN_LRU) begin
          if (cur_r == '0 || e_stamp <= best_stamp_r) begin
            best_r       <= cur_r;
            best_stamp_r <= e_stamp;
            best_len_r   <= e_len;
          end
          if (e_last) begin
            scan_busy_r <= 1'b0;
          end
        end else if (e_match) begin
          hit_r       <= 1'b1;
          scan_busy_r <= 1'b0;
          if (mode_r != SCAN_KEY) begin
            slot_r       <= cur_r;
            slot_valid_r <= 1'b1;
            m_start_r    <= e_start;
            m_len_r      <= e_len;
          end
        end else if (e_last) begin
          scan_busy_r <= 1'b0;
        end
      end

      if (div_busy_r) begin
        div_rem_r <= r2_nxt[6:0];
        div_sh_r  <= div_sh_r << 1;
        div_cnt_r <= div_cnt_r - CW'(1);
        if (div_cnt_r == CW'(1)) begin
          div_busy_r <= 1'b0;
        end
      end

      case (cmd.op)
        CMD_LATCH: begin
          req_r        <= req_t'(in_req_type);
          pos_r        <= in_position;
          cnt_r        <= in_item_count;
          slot_r       <= '0;
          slot_valid_r <= 1'b0;
          dropped_r    <= '0;
          reject_r     <= 1'b0;
          pvalid_r     <= 1'b0;
          pstart_r     <= '0;
          want_r       <= 1'b0;
        end
        CMD_SEED: begin
          used_r  <= used_r + UW'(1);
          clock_r <= clock_r + 32'd1;
        end
        CMD_SCAN: begin
          cur_r       <= '0;
          mode_r      <= cmd.mode;
          hit_r       <= 1'b0;
          scan_busy_r <= used_r != '0;
        end
        CMD_BUMP: begin
          m_len_r <= m_len_r + 7'd1;
          clock_r <= clock_r + 32'd1;
          total_r <= total_r + TW'(1);
        end
        CMD_SHRINK: begin
          clock_r <= clock_r + 32'd1;
          total_r <= total_r - TW'(1);
        end
        CMD_TOUCH: begin
          clock_r <= clock_r + 32'd1;
        end
        CMD_DROP: begin
          used_r  <= used_r - UW'(1);
          total_r <= total_r - TW'(best_len_r);
          if (dropped_r != 3'd7) begin
            dropped_r <= dropped_r + 3'd1;
          end
          if (slot_valid_r) begin
            if (slot_r == best_r) begin
              slot_valid_r <= 1'b0;
            end else if (slot_r > best_r) begin
              slot_r <= slot_r - SW'(1);
            end
          end
        end
        CMD_SPLIT: begin
          used_r <= used_r + UW'(1);
        end
        CMD_CLEAR: begin
          used_r  <= '0;
          total_r <= '0;
        end
        CMD_CNT_INIT: begin
          rem_r <= cnt_r;
          add_r <= '0;
        end
        CMD_CNT_STEP: begin
          rem_r <= (rem_r > 10'(ps)) ? rem_r - 10'(ps) : 10'd0;
          add_r <= add_r + 4'd1;
        end
        CMD_REJECT: begin
          reject_r <= 1'b1;
        end
        CMD_BLK_INIT: begin
          bi_r   <= '0;
          bst_r  <= {1'b0, pos_r};
          left_r <= cnt_r;
        end
        CMD_BLK_APPEND: begin
          if (bi_r == 4'd0) begin
            slot_r       <= used_r[SW-1:0];
            slot_valid_r <= 1'b1;
          end
          used_r  <= used_r + UW'(1);
          clock_r <= clock_r + 32'd1;
          total_r <= total_r + TW'(blk_len);
          bi_r    <= bi_r + 4'd1;
          bst_r   <= bst_nxt;
          left_r  <= (left_r > 10'(ps)) ? left_r - 10'(ps) : 10'd0;
        end
        CMD_PROBE: begin
          if (d_lo <= PW'(cfg_margin)) begin
            want_r <= m_start_r != '0;
            key_r  <= {1'b0, m_start_r} - KW'(1);
          end else if (d_hi <= KW'(cfg_margin)) begin
            want_r <= 1'b1;
            key_r  <= m_end;
          end else begin
            want_r <= 1'b0;
          end
        end
        CMD_DIV: begin
          div_rem_r  <= '0;
          div_sh_r   <= key_r;
          div_cnt_r  <= CW'(KW);
          div_busy_r <= 1'b1;
        end
        CMD_ALIGN: begin
          key_r <= key_r - KW'(div_rem_r);
        end
        CMD_PF_SET: begin
          pvalid_r <= 1'b1;
          pstart_r <= key_r[PW-1:0];
        end
        CMD_OUT_LOAD: begin
          if (reject_r) begin
            o_status_r <= ST_REJECT;
          end else if (miss) begin
            o_status_r <= ST_MISS;
          end else begin
            o_status_r <= ST_DONE;
          end
          o_slot_r    <= slot_valid_r ? slot_x[2:0] : 3'd0;
          o_dropped_r <= dropped_r;
          o_pvalid_r  <= pvalid_r;
          o_pstart_r  <= pstart_r;
          o_fetch_r   <= (ps >= PS_HALF) ? FETCH_HI : ps << 1;
          o_used_r    <= (used_x > UWX'(7)) ? 3'd7 : used_x[2:0];
          o_items_r   <= (total_r > TW'(1023)) ? 10'd1023 : total_r[9:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign out_status         = o_status_r;
  assign out_page_slot      = o_slot_r;
  assign out_pages_dropped  = o_dropped_r;
  assign out_prefetch_valid = o_pvalid_r;
  assign out_prefetch_start = o_pstart_r;
  assign out_fetch_size     = o_fetch_r;
  assign out_pages_in_use   = o_used_r;
  assign out_items_cached   = o_items_r;

endmodule
`default_nettype wire

// ===== sv/rpd_ctrl.sv =====
// Request sequencer that drives the directory datapath.
`timescale 1ns / 1ps
`default_nettype none
module rpd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  rpd_pkg::dp_stat_t  stat,
  output rpd_pkg::dp_cmd_t   cmd
);
  import rpd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND_ADJ,
    S_FIND_WAIT,
    S_INS_SHIFT,
    S_INS_LRU1,
    S_INS_DROP1,
    S_INS_SPLIT,
    S_INS_CAP,
    S_INS_DROP2,
    S_RM_SHIFT,
    S_LD_CNT,
    S_LD_CHK,
    S_LD_EVICT,
    S_LD_DROP,
    S_LD_APPEND,
    S_PF_SCAN1,
    S_PF_WAIT1,
    S_PF_DIV,
    S_PF_CHK,
    S_PF_WAIT2,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   load;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign load      = state_r == S_FINISH && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = CMD_NOP;
    cmd.mode  = SCAN_HOLD;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = CMD_LATCH;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.req)
          REQ_INSERT: begin
            if (stat.used_zero) begin
              cmd.op = CMD_SEED;
            end
            state_nxt = S_FIND_ADJ;
          end
          REQ_REMOVE, REQ_READ, REQ_PREFETCH: begin
            cmd.op    = CMD_SCAN;
            state_nxt = S_FIND_WAIT;
          end
          REQ_LOAD: begin
            cmd.op    = CMD_CNT_INIT;
            state_nxt = S_LD_CNT;
          end
          REQ_CLEAR: begin
            cmd.op    = CMD_CLEAR;
            state_nxt = S_FINISH;
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_FIND_ADJ: begin
        cmd.op    = CMD_SCAN;
        cmd.mode  = SCAN_ADJ;
        state_nxt = S_FIND_WAIT;
      end
      S_FIND_WAIT: begin
        if (!stat.busy) begin
          case (stat.req)
            REQ_INSERT: begin
              if (stat.hit) begin
                cmd.op = CMD_BUMP;
              end
              state_nxt = S_INS_SHIFT;
            end
            REQ_REMOVE: begin
              if (stat.hit) begin
                cmd.op = CMD_SHRINK;
              end
              state_nxt = S_RM_SHIFT;
            end
            REQ_READ: begin
              if (stat.hit) begin
                cmd.op = CMD_TOUCH;
              end
              state_nxt = S_FINISH;
            end
            REQ_PREFETCH: begin
              if (stat.hit) begin
                cmd.op    = CMD_PROBE;
                state_nxt = S_PF_SCAN1;
              end else begin
                state_nxt = S_FINISH;
              end
            end
            default: begin
              state_nxt = S_FINISH;
            end
          endcase
        end
      end
      S_INS_SHIFT: begin
        cmd.op = CMD_SHIFT_UP;
        if (stat.slot_valid && stat.split_need) begin
          state_nxt = stat.used_full ? S_INS_LRU1 : S_INS_SPLIT;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_INS_LRU1: begin
        cmd.op    = CMD_SCAN;
        cmd.mode  = SCAN_LRU;
        state_nxt = S_INS_DROP1;
      end
      S_INS_DROP1: begin
        if (!stat.busy) begin
          cmd.op    = CMD_DROP;
          state_nxt = S_INS_SPLIT;
        end
      end
      S_INS_SPLIT: begin
        if (stat.slot_valid) begin
          cmd.op    = CMD_SPLIT;
          state_nxt = S_INS_CAP;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_INS_CAP: begin
        if (stat.over_cap) begin
          cmd.op    = CMD_SCAN;
          cmd.mode  = SCAN_LRU;
          state_nxt = S_INS_DROP2;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_INS_DROP2: begin
        if (!stat.busy) begin
          cmd.op    = CMD_DROP;
          state_nxt = S_FINISH;
        end
      end
      S_RM_SHIFT: begin
        cmd.op    = CMD_SHIFT_DN;
        state_nxt = S_FINISH;
      end
      S_LD_CNT: begin
        if (stat.cnt_end) begin
          state_nxt = S_LD_CHK;
        end else begin
          cmd.op = CMD_CNT_STEP;
        end
      end
      S_LD_CHK: begin
        if (stat.add_over) begin
          cmd.op    = CMD_REJECT;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_LD_EVICT;
        end
      end
      S_LD_EVICT: begin
        if (stat.evict_need) begin
          cmd.op    = CMD_SCAN;
          cmd.mode  = SCAN_LRU;
          state_nxt = S_LD_DROP;
        end else begin
          cmd.op    = CMD_BLK_INIT;
          state_nxt = S_LD_APPEND;
        end
      end
      S_LD_DROP: begin
        if (!stat.busy) begin
          cmd.op    = CMD_DROP;
          state_nxt = S_LD_EVICT;
        end
      end
      S_LD_APPEND: begin
        if (stat.blk_more) begin
          cmd.op = CMD_BLK_APPEND;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_PF_SCAN1: begin
        if (stat.want) begin
          cmd.op    = CMD_SCAN;
          cmd.mode  = SCAN_KEY;
          state_nxt = S_PF_WAIT1;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_PF_WAIT1: begin
        if (!stat.busy) begin
          if (!stat.hit) begin
            cmd.op    = CMD_DIV;
            state_nxt = S_PF_DIV;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_PF_DIV: begin
        if (!stat.busy) begin
          cmd.op    = CMD_ALIGN;
          state_nxt = S_PF_CHK;
        end
      end
      S_PF_CHK: begin
        if (stat.al_ok) begin
          cmd.op    = CMD_SCAN;
          cmd.mode  = SCAN_KEY;
          state_nxt = S_PF_WAIT2;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_PF_WAIT2: begin
        if (!stat.busy) begin
          if (!stat.hit) begin
            cmd.op = CMD_PF_SET;
          end
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (load) begin
          cmd.op    = CMD_OUT_LOAD;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/range_page_directory_lru_top.sv =====
// Top level of the range page directory: configuration registers and core.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------------
//   in_      | in_valid / in_ready       | req_type, position, item_count
//   out_     | out_valid / out_ready     | status, page_slot, pages_dropped, prefetch
//   config   | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// A prefetch with alignment can run a position scan, a key scan, the remainder
// unit and a second key scan. Scans visit one slot per cycle and the remainder
// unit retires one position bit per cycle.
// Reset is synchronous and empties the directory; no clearing pass follows.
// A finished result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none
module range_page_directory_lru_top #(
  parameter int PAGE_SLOTS    = 8,
  parameter int POSITION_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 in_req_type,
  input  logic [POSITION_BITS-1:0]   in_position,
  input  logic [9:0]                 in_item_count,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_status,
  output logic [2:0]                 out_page_slot,
  output logic [2:0]                 out_pages_dropped,
  output logic                       out_prefetch_valid,
  output logic [POSITION_BITS-1:0]   out_prefetch_start,
  output logic [6:0]                 out_fetch_size,
  output logic [2:0]                 out_pages_in_use,
  output logic [9:0]                 out_items_cached,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rpd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import rpd_pkg::*;

  logic [6:0] page_size_r;
  logic [2:0] max_pages_r;
  logic [6:0] margin_r;
  reg_idx_t   reg_idx;
  dp_cmd_t    cmd;
  dp_stat_t   stat;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_r <= PS_RST;
      max_pages_r <= MP_RST;
      margin_r    <= PM_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_PAGE_SIZE: page_size_r <= pwdata[6:0];
        REG_MAX_PAGES: max_pages_r <= pwdata[2:0];
        REG_PF_MARGIN: margin_r    <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PAGE_SIZE: prdata = {25'd0, page_size_r};
      REG_MAX_PAGES: prdata = {29'd0, max_pages_r};
      REG_PF_MARGIN: prdata = {25'd0, margin_r};
      default:       prdata = 32'd0;
    endcase
  end

  rpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rpd_datapath #(
    .PAGE_SLOTS    (PAGE_SLOTS),
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_page_size      (page_size_r),
    .cfg_max_pages      (max_pages_r),
    .cfg_margin         (margin_r),
    .in_req_type        (in_req_type),
    .in_position        (in_position),
    .in_item_count      (in_item_count),
    .out_status         (out_status),
    .out_page_slot      (out_page_slot),
    .out_pages_dropped  (out_pages_dropped),
    .out_prefetch_valid (out_prefetch_valid),
    .out_prefetch_start (out_prefetch_start),
    .out_fetch_size     (out_fetch_size),
    .out_pages_in_use   (out_pages_in_use),
    .out_items_cached   (out_items_cached)
  );

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the range page directory with LRU page eviction.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import rpd_pkg::*;

  localparam int SLOTS = 8;
  localparam longint POS_MAX = 64'hFF_FFFF;
  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;
  localparam int SETTLE = 80;

  typedef struct {
    logic [1:0]  status;
    logic [2:0]  slot;
    logic [2:0]  dropped;
    logic        pf_valid;
    logic [23:0] pf_start;
    logic [6:0]  fetch;
    logic [2:0]  in_use;
    logic [9:0]  items;
  } dir_result_t;

  typedef struct {
    logic [2:0]  req;
    logic [23:0] pos;
    logic [9:0]  cnt;
    bit          typed;
    dir_result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_req_type = '0;
  logic [23:0] in_position = '0;
  logic [9:0] in_item_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [2:0] out_page_slot;
  logic [2:0] out_pages_dropped;
  logic out_prefetch_valid;
  logic [23:0] out_prefetch_start;
  logic [6:0] out_fetch_size;
  logic [2:0] out_pages_in_use;
  logic [9:0] out_items_cached;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #5 clk = ~clk;

  range_page_directory_lru_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_position(in_position), .in_item_count(in_item_count),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_page_slot(out_page_slot), .out_pages_dropped(out_pages_dropped),
    .out_prefetch_valid(out_prefetch_valid), .out_prefetch_start(out_prefetch_start),
    .out_fetch_size(out_fetch_size), .out_pages_in_use(out_pages_in_use),
    .out_items_cached(out_items_cached),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the directory.
  longint pg_start [SLOTS];
  longint pg_len [SLOTS];
  bit [31:0] pg_stamp [SLOTS];
  int dir_used;
  bit [31:0] use_clk;
  int cfg_ps, cfg_mp, cfg_pm;

  dir_result_t pending_q[$];
  int err_cnt = 0;
  int req_cnt = 0;
  int result_cnt = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int pf_hits = 0;
  int drops_seen = 0;

  function automatic bit [31:0] next_stamp();
    use_clk = use_clk + 1;
    return use_clk;
  endfunction

  function automatic int page_size_eff();
    return cfg_ps < 25 ? 25 : (cfg_ps > 100 ? 100 : cfg_ps);
  endfunction

  function automatic int max_pages_eff();
    return cfg_mp < 2 ? 2 : (cfg_mp > 7 ? 7 : cfg_mp);
  endfunction

  function automatic int holding_page(longint pos);
    for (int i = 0; i < dir_used; i++)
      if (pos >= pg_start[i] && pos < pg_start[i] + pg_len[i]) return i;
    return -1;
  endfunction

  function automatic longint cached_total();
    longint s = 0;
    for (int i = 0; i < dir_used; i++) s += pg_len[i];
    return s;
  endfunction

  function automatic void evict_lru(inout int track);
    int v = 0;
    if (dir_used == 0) return;
    for (int i = 1; i < dir_used; i++)
      if (pg_stamp[i] <= pg_stamp[v]) v = i;
    for (int i = v; i < dir_used - 1; i++) begin
      pg_start[i] = pg_start[i+1];
      pg_len[i] = pg_len[i+1];
      pg_stamp[i] = pg_stamp[i+1];
    end
    dir_used--;
    if (track == v) track = -1;
    else if (track > v) track--;
  endfunction

  function automatic void add_page(longint start, longint len, bit [31:0] stamp);
    if (dir_used >= SLOTS) return;
    pg_start[dir_used] = start;
    pg_len[dir_used] = len;
    pg_stamp[dir_used] = stamp;
    dir_used++;
  endfunction

  function automatic void directory_reset();
    dir_used = 0;
    use_clk = 1;
    cfg_ps = PS_RST;
    cfg_mp = MP_RST;
    cfg_pm = PM_RST;
  endfunction

  function automatic dir_result_t apply_request(logic [2:0] req, longint pos, int cnt);
    dir_result_t r;
    int ps = page_size_eff();
    int mp = max_pages_eff();
    int slot = -1;
    int dropped = 0;
    int add;
    longint st, pend, probe, al, items;
    bit want;
    r.status = ST_DONE;
    r.pf_valid = 1'b0;
    r.pf_start = '0;
    case (req)
      REQ_INSERT: begin
        if (dir_used == 0) add_page(pos, 0, next_stamp());
        for (int i = 0; i < dir_used; i++)
          if (pos >= pg_start[i] && pos <= pg_start[i] + pg_len[i]) begin
            slot = i;
            break;
          end
        if (slot >= 0) begin
          pg_len[slot] += 1;
          pg_stamp[slot] = next_stamp();
        end
        for (int i = 0; i < dir_used; i++)
          if (pg_start[i] > pos && pg_start[i] < POS_MAX) pg_start[i] += 1;
        if (slot >= 0 && pg_len[slot] > ps) begin
          longint len = pg_len[slot];
          longint lo = len / 2;
          longint hs = pg_start[slot] + lo;
          bit [31:0] stamp = pg_stamp[slot];
          if (dir_used >= SLOTS) begin
            evict_lru(slot);
            dropped++;
          end
          if (slot >= 0) begin
            if (hs > POS_MAX) hs = POS_MAX;
            pg_len[slot] = lo;
            add_page(hs, len - lo, stamp);
            if (cached_total() > ps * mp) begin
              evict_lru(slot);
              dropped++;
            end
          end
        end
        if (slot < 0 && dropped == 0) r.status = ST_MISS;
      end
      REQ_REMOVE: begin
        slot = holding_page(pos);
        if (slot >= 0) begin
          pg_len[slot] -= 1;
          pg_stamp[slot] = next_stamp();
        end
        for (int i = 0; i < dir_used; i++)
          if (pg_start[i] > pos) pg_start[i] -= 1;
        if (slot < 0) r.status = ST_MISS;
      end
      REQ_LOAD: begin
        add = cnt / ps + ((cnt % ps) != 0);
        if (add > mp) r.status = ST_REJECT;
        else begin
          while (dir_used + add > mp && dir_used > 0) begin
            evict_lru(slot);
            dropped++;
          end
          for (int i = 0; i < add; i++) begin
            st = pos + longint'(i) * ps;
            if (st > POS_MAX) st = POS_MAX;
            if (i == 0) slot = dir_used;
            add_page(st, (cnt - i * ps) < ps ? cnt - i * ps : ps, next_stamp());
          end
        end
      end
      REQ_READ: begin
        slot = holding_page(pos);
        if (slot >= 0) pg_stamp[slot] = next_stamp();
        else r.status = ST_MISS;
      end
      REQ_PREFETCH: begin
        slot = holding_page(pos);
        if (slot >= 0) begin
          st = pg_start[slot];
          pend = st + pg_len[slot];
          want = 1'b0;
          probe = 0;
          if (pos - st <= cfg_pm) begin
            if (st > 0) begin
              probe = st - 1;
              want = 1'b1;
            end
          end else if (pend - pos <= cfg_pm) begin
            probe = pend;
            want = 1'b1;
          end
          if (want && holding_page(probe) < 0) begin
            al = (probe / ps) * ps;
            if (al <= POS_MAX && holding_page(al) < 0) begin
              r.pf_valid = 1'b1;
              r.pf_start = al[23:0];
            end
          end
        end else r.status = ST_MISS;
      end
      REQ_CLEAR: dir_used = 0;
      default: ;
    endcase
    items = cached_total();
    r.slot = slot >= 0 ? slot[2:0] : 3'd0;
    r.dropped = dropped > 7 ? 3'd7 : dropped[2:0];
    r.fetch = 2 * ps > 100 ? 7'd100 : 7'(2 * ps);
    r.in_use = dir_used > 7 ? 3'd7 : dir_used[2:0];
    r.items = items > 1023 ? 10'd1023 : items[9:0];
    return r;
  endfunction

  task automatic cfg_write(reg_idx_t idx, logic [6:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= {25'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PAGE_SIZE: cfg_ps = value;
      REG_MAX_PAGES: cfg_mp = value[2:0];
      default: cfg_pm = value;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Called at a rising edge; returns after the request is taken and any idle gap ends.
  task automatic send_request(logic [2:0] req, logic [23:0] pos, logic [9:0] cnt,
                              bit typed, dir_result_t typed_res);
    dir_result_t r;
    int gap;
    in_valid <= 1'b1;
    in_req_type <= req;
    in_position <= pos;
    in_item_count <= cnt;
    do @(posedge clk); while (!in_ready);
    r = apply_request(req, pos, cnt);
    pending_q.push_back(typed ? typed_res : r);
    req_cnt++;
    if (r.pf_valid) pf_hits++;
    if (r.dropped != 0) drops_seen++;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    int pick = $urandom_range(99);
    int sel;
    logic [2:0] req;
    longint pos;
    int cnt;
    dir_result_t none;
    none = '{default: '0};
    if (pick < 35) req = REQ_INSERT;
    else if (pick < 50) req = REQ_REMOVE;
    else if (pick < 62) req = REQ_LOAD;
    else if (pick < 73) req = REQ_READ;
    else if (pick < 94) req = REQ_PREFETCH;
    else if (pick < 97) req = REQ_CLEAR;
    else req = $urandom_range(1) ? REQ_SPARE6 : REQ_SPARE7;
    sel = $urandom_range(99);
    if (sel < 65 && dir_used > 0) begin
      int k = $urandom_range(dir_used - 1);
      pos = pg_start[k] + longint'($urandom_range(pg_len[k] + 4)) - 2;
    end else if (sel < 80) pos = $urandom_range(400);
    else if (sel < 90) pos = POS_MAX - $urandom_range(300);
    else pos = $urandom_range(24'hFF_FFFF);
    if (pos < 0) pos = 0;
    if (pos > POS_MAX) pos = POS_MAX;
    if ($urandom_range(9) == 0) cnt = $urandom_range(1023);
    else cnt = $urandom_range(page_size_eff() * max_pages_eff());
    send_request(req, pos[23:0], cnt[9:0], 1'b0, none);
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, out_status);
        err_cnt++;
      end else begin
        dir_result_t e;
        e = pending_q.pop_front();
        result_cnt++;
        check_field("status", e.status, out_status);
        check_field("page_slot", e.slot, out_page_slot);
        check_field("pages_dropped", e.dropped, out_pages_dropped);
        check_field("prefetch_valid", e.pf_valid, out_prefetch_valid);
        check_field("prefetch_start", e.pf_start, out_prefetch_start);
        check_field("fetch_size", e.fetch, out_fetch_size);
        check_field("pages_in_use", e.in_use, out_pages_in_use);
        check_field("items_cached", e.items, out_items_cached);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    logic [6:0] ps_set [4];
    logic [6:0] mp_set [4];
    logic [6:0] pm_set [4];
    int idle_set [4];
    int stall_set [4];
    directory_reset();
    row.typed = 1'b0;
    row.res = '{default: '0};
    rows.push_back('{REQ_READ, 24'd0, 10'd0, 1'b1, '{ST_MISS, 0, 0, 0, 0, 100, 0, 0}});
    rows.push_back('{REQ_REMOVE, 24'd5, 10'd0, 1'b1, '{ST_MISS, 0, 0, 0, 0, 100, 0, 0}});
    rows.push_back('{REQ_PREFETCH, 24'd0, 10'd0, 1'b1, '{ST_MISS, 0, 0, 0, 0, 100, 0, 0}});
    rows.push_back('{REQ_INSERT, 24'd100, 10'd0, 1'b1, '{ST_DONE, 0, 0, 0, 0, 100, 1, 1}});
    rows.push_back('{REQ_LOAD, 24'd1000, 10'd120, 1'b1,
                     '{ST_DONE, 1, 0, 0, 0, 100, 4, 121}});
    rows.push_back('{REQ_LOAD, 24'd0, 10'd400, 1'b1,
                     '{ST_REJECT, 0, 0, 0, 0, 100, 4, 121}});
    rows.push_back('{REQ_READ, 24'd1050, 10'd0, 1'b1, '{ST_DONE, 2, 0, 0, 0, 100, 4, 121}});
    rows.push_back('{REQ_PREFETCH, 24'd1005, 10'd0, 1'b0, row.res});
    rows.push_back('{REQ_PREFETCH, 24'd1115, 10'd0, 1'b0, row.res});
    rows.push_back('{REQ_PREFETCH, 24'd1070, 10'd0, 1'b0, row.res});
    rows.push_back('{REQ_INSERT, 24'd1020, 10'd1023, 1'b0, row.res});
    rows.push_back('{REQ_REMOVE, 24'd1149, 10'd0, 1'b0, row.res});
    rows.push_back('{REQ_INSERT, 24'hFF_FFFF, 10'd0, 1'b0, row.res});
    rows.push_back('{REQ_LOAD, 24'hFF_FFF0, 10'd100, 1'b0, row.res});
    rows.push_back('{REQ_PREFETCH, 24'hFF_FFFF, 10'd0, 1'b0, row.res});
    rows.push_back('{REQ_READ, 24'hFF_FFFF, 10'd0, 1'b0, row.res});
    rows.push_back('{REQ_REMOVE, 24'd100, 10'd0, 1'b0, row.res});
    rows.push_back('{REQ_SPARE7, 24'hAA_AAAA, 10'h2AA, 1'b0, row.res});
    rows.push_back('{REQ_CLEAR, 24'h55_5555, 10'h155, 1'b1,
                     '{ST_DONE, 0, 0, 0, 0, 100, 0, 0}});
    rows.push_back('{REQ_SPARE6, 24'd0, 10'd0, 1'b1, '{ST_DONE, 0, 0, 0, 0, 100, 0, 0}});
    rows.push_back('{REQ_LOAD, 24'd0, 10'd0, 1'b1, '{ST_DONE, 0, 0, 0, 0, 100, 0, 0}});
    rows.push_back('{REQ_LOAD, 24'd0, 10'd250, 1'b0, row.res});
    rows.push_back('{REQ_PREFETCH, 24'd245, 10'd0, 1'b0, row.res});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send_request(rows[i].req, rows[i].pos, rows[i].cnt,
                                   rows[i].typed, rows[i].res);
    in_valid <= 1'b0;

    ps_set = '{7'd25, 7'd100, 7'($urandom_range(127)), 7'd50};
    mp_set = '{7'd2, 7'd7, 7'($urandom_range(7)), 7'd5};
    pm_set = '{7'd0, 7'd100, 7'($urandom_range(127)), 7'd10};
    idle_set = '{0, 66, 0, 33};
    stall_set = '{0, 0, 66, 33};
    for (int ph = 0; ph < 4; ph++) begin
      @(posedge clk);
      wait_drained();
      cfg_write(REG_PAGE_SIZE, ps_set[ph]);
      cfg_write(REG_MAX_PAGES, mp_set[ph]);
      cfg_write(REG_PF_MARGIN, pm_set[ph]);
      send_idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      for (int n = 0; n < 100; n++) begin
        if (n == 50) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_q.size() != 0) @(posedge clk);
        end
        send_random();
      end
      in_valid <= 1'b0;
    end
    @(posedge clk);
    wait_drained();
    $display("Covered %0d requests and %0d results over four settings of page size,",
             req_cnt, result_cnt);
    $display("page limit and margin; %0d prefetch hints, %0d requests with evictions.",
             pf_hits, drops_seen);
    if (err_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// ===== range_page_directory_lru_top.f =====
sv/rpd_pkg.sv
sv/rpd_datapath.sv
sv/rpd_ctrl.sv
sv/range_page_directory_lru_top.sv
sim/tb_top.sv
